[rtl/core/tlbfa_pkg.sv]
package tlbfa_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OP_W    = 2;
   localparam int VPN_W   = 32;
   localparam int PPN_W   = 20;
   localparam int CYC_W   = 32;
   localparam int SLOT_W  = 4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
   localparam logic [OP_W-1:0] OP_PF_FILL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [VPN_W-1:0] vpn;
      logic [PPN_W-1:0] ppn;
      logic [CYC_W-1:0] cycle;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [PPN_W-1:0]  ppn_out;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // one entry as seen on the store's read port
   typedef struct packed {
      logic             valid;
      logic [VPN_W-1:0] tag;
      logic [PPN_W-1:0] frame;
      logic [CYC_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             wr_fill;
      logic             wr_stamp;
      logic             clr_valid;
      logic [IDX_W-1:0] idx;
      logic [VPN_W-1:0] tag;
      logic [PPN_W-1:0] frame;
      logic [CYC_W-1:0] stamp;
   } store_cmd_type;

   typedef struct packed {
      logic             start;
      logic             step;
      logic [OP_W-1:0]  op;
      logic [VPN_W-1:0] vpn;
      logic [PPN_W-1:0] ppn;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic             hit;
      logic [PPN_W-1:0] hit_frame;
      logic [IDX_W-1:0] hit_idx;
      logic [IDX_W-1:0] victim_idx;
      logic             touch;
      logic             kill;
   } scan_res_type;

endpackage

[rtl/core/tlbfa_store.sv]
module tlbfa_store (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [tlbfa_pkg::IDX_W-1:0] rd_idx,
   output tlbfa_pkg::entry_type    rd_entry,
   input  tlbfa_pkg::store_cmd_type cmd
);
   import tlbfa_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [VPN_W-1:0]   tag_ff   [ENTRIES];
   logic [PPN_W-1:0]   frame_ff [ENTRIES];
   logic [CYC_W-1:0]   stamp_ff [ENTRIES];

   always_comb begin
      rd_entry.valid = valid_ff[rd_idx];
      rd_entry.tag   = tag_ff[rd_idx];
      rd_entry.frame = frame_ff[rd_idx];
      rd_entry.stamp = stamp_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.clr_valid) begin
            valid_ff[cmd.idx] <= 1'b0;
         end
         if (cmd.wr_fill) begin
            valid_ff[cmd.idx] <= 1'b1;
         end
      end
   end

   // stamps are only read for valid entries, which always got one on fill
   always_ff @(posedge clock) begin
      if (cmd.wr_fill) begin
         tag_ff[cmd.idx]   <= cmd.tag;
         frame_ff[cmd.idx] <= cmd.frame;
      end
      if (cmd.wr_fill || cmd.wr_stamp) begin
         stamp_ff[cmd.idx] <= cmd.stamp;
      end
   end

endmodule

[rtl/core/tlbfa_scan.sv]
module tlbfa_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  tlbfa_pkg::scan_ctl_type ctl,
   input  tlbfa_pkg::entry_type   rd_entry,
   output tlbfa_pkg::scan_res_type res
);
   import tlbfa_pkg::*;

   logic             hit_ff, hit_in;
   logic [PPN_W-1:0] hit_frame_ff, hit_frame_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             have_min_ff, have_min_in;
   logic [CYC_W-1:0] min_stamp_ff, min_stamp_in;
   logic [IDX_W-1:0] min_idx_ff, min_idx_in;

   logic tag_eq, frame_eq, eff_valid, is_lookup, is_pf;

   always_comb begin
      is_lookup = (ctl.op == OP_LOOKUP);
      is_pf     = (ctl.op == OP_PF_FILL);
      tag_eq    = rd_entry.valid && (rd_entry.tag == ctl.vpn);
      frame_eq  = rd_entry.valid && (rd_entry.frame == ctl.ppn);
      // an entry dropped by the page-fault pass counts as free right away
      eff_valid = rd_entry.valid && !(is_pf && frame_eq);

      hit_in       = hit_ff;
      hit_frame_in = hit_frame_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      have_min_in  = have_min_ff;
      min_stamp_in = min_stamp_ff;
      min_idx_in   = min_idx_ff;

      if (ctl.start) begin
         hit_in       = 1'b0;
         hit_frame_in = '0;
         hit_idx_in   = '0;
         free_in      = 1'b0;
         free_idx_in  = '0;
         have_min_in  = 1'b0;
         min_stamp_in = '0;
         min_idx_in   = '0;
      end else if (ctl.step) begin
         if (is_lookup && tag_eq && !hit_ff) begin
            hit_in       = 1'b1;
            hit_frame_in = rd_entry.frame;
            hit_idx_in   = ctl.idx;
         end
         if (!eff_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ctl.idx;
         end
         if (eff_valid && (!have_min_ff || (rd_entry.stamp < min_stamp_ff))) begin
            have_min_in  = 1'b1;
            min_stamp_in = rd_entry.stamp;
            min_idx_in   = ctl.idx;
         end
      end

      res.hit        = hit_ff;
      res.hit_frame  = hit_frame_ff;
      res.hit_idx    = hit_idx_ff;
      res.victim_idx = free_ff ? free_idx_ff : min_idx_ff;
      res.touch      = ctl.step && is_lookup && tag_eq;
      res.kill       = ctl.step && is_pf && frame_eq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         have_min_ff <= 1'b0;
      end else begin
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         have_min_ff <= have_min_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_frame_ff <= hit_frame_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff   <= min_idx_in;
   end

endmodule

[rtl/core/tlb_fully_assoc_lru_unit.sv]
// Fully associative TLB with LRU replacement by timestamps. Ops: lookup (hit,
// frame and slot; touches the stamp of every matching entry), fill (first free
// entry, else oldest stamp, lowest index on ties) and page-fault fill (drops
// entries with the same frame, then fills); op 3 returns all zeros without a
// scan. The other ops walk the entries one per cycle through a single compare
// unit; req_stall is held high until the result transfer completes.
module tlb_fully_assoc_lru_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlbfa_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlbfa_pkg::rsp_type rsp_data
);
   import tlbfa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic          req_xfer;
   scan_ctl_type  scan_ctl;
   scan_res_type  scan_res;
   entry_type     rd_entry;
   store_cmd_type cmd;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      scan_ctl.start = req_xfer;
      scan_ctl.step  = (state_ff == S_SCAN);
      scan_ctl.op    = req_ff.op;
      scan_ctl.vpn   = req_ff.vpn;
      scan_ctl.ppn   = req_ff.ppn;
      scan_ctl.idx   = idx_ff;

      cmd.wr_fill   = (state_ff == S_DONE) && (req_ff.op != OP_LOOKUP);
      cmd.wr_stamp  = scan_res.touch;
      cmd.clr_valid = scan_res.kill;
      cmd.idx       = (state_ff == S_DONE) ? scan_res.victim_idx : idx_ff;
      cmd.tag       = req_ff.vpn;
      cmd.frame     = req_ff.ppn;
      cmd.stamp     = req_ff.cycle;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               req_in = req_data;
               idx_in = '0;
               if (req_data.op == OP_LOOKUP || req_data.op == OP_FILL ||
                   req_data.op == OP_PF_FILL) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_in   = '0;
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (req_ff.op == OP_LOOKUP) begin
               rsp_in.hit     = scan_res.hit;
               rsp_in.ppn_out = scan_res.hit ? scan_res.hit_frame : '0;
               rsp_in.slot    = SLOT_W'(scan_res.hit_idx);
            end else begin
               rsp_in.hit     = 1'b0;
               rsp_in.ppn_out = '0;
               rsp_in.slot    = SLOT_W'(scan_res.victim_idx);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   tlbfa_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .rd_entry (rd_entry),
      .cmd      (cmd)
   );

   tlbfa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .rd_entry (rd_entry),
      .res      (scan_res)
   );

endmodule

[sim/tb_tlb_fully_assoc_lru_unit.sv]
`timescale 1ns / 1ps

module tb_tlb_fully_assoc_lru_unit;
   import tlbfa_pkg::*;

   localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

   localparam int RAND_ITEMS     = 1100;
   localparam int VPN_POOL_SZ    = 24;
   localparam int PPN_POOL_SZ    = 12;
   localparam int DRAIN_CYCLES   = 50;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the translation store
   logic             valid_mem [ENTRIES];
   logic [VPN_W-1:0] tag_mem   [ENTRIES];
   logic [PPN_W-1:0] frame_mem [ENTRIES];
   logic [CYC_W-1:0] stamp_mem [ENTRIES];

   req_type tlb_op_q[$];
   rsp_type xlat_result_q[$];

   int total_ops;
   int accepted_ops;
   int err_cnt   = 0;
   int stall_run = 0;

   tlb_fully_assoc_lru_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // applies one op to the shadow store, returns the translation result
   function automatic rsp_type xlat_apply(req_type r);
      rsp_type          res;
      int               victim;
      logic [CYC_W-1:0] oldest;
      logic             found;
      res = '0;
      if (r.op == OP_LOOKUP) begin
         found = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_mem[i] && tag_mem[i] == r.vpn) begin
               if (!found) begin
                  found       = 1'b1;
                  res.hit     = 1'b1;
                  res.ppn_out = frame_mem[i];
                  res.slot    = SLOT_W'(i);
               end
               stamp_mem[i] = r.cycle;
            end
         end
      end else if (r.op == OP_FILL || r.op == OP_PF_FILL) begin
         if (r.op == OP_PF_FILL) begin
            for (int i = 0; i < ENTRIES; i++)
               if (valid_mem[i] && frame_mem[i] == r.ppn) valid_mem[i] = 1'b0;
         end
         victim = -1;
         for (int i = 0; i < ENTRIES && victim < 0; i++)
            if (!valid_mem[i]) victim = i;
         if (victim < 0) begin
            victim = 0;
            oldest = stamp_mem[0];
            for (int i = 1; i < ENTRIES; i++) begin
               if (stamp_mem[i] < oldest) begin
                  oldest = stamp_mem[i];
                  victim = i;
               end
            end
         end
         valid_mem[victim] = 1'b1;
         tag_mem[victim]   = r.vpn;
         frame_mem[victim] = r.ppn;
         stamp_mem[victim] = r.cycle;
         res.slot          = SLOT_W'(victim);
      end
      return res;
   endfunction

   task automatic push_op(logic [OP_W-1:0] op, logic [VPN_W-1:0] vpn,
                          logic [PPN_W-1:0] ppn, logic [CYC_W-1:0] cyc);
      req_type r;
      r.op    = op;
      r.vpn   = vpn;
      r.ppn   = ppn;
      r.cycle = cyc;
      tlb_op_q.push_back(r);
   endtask

   function automatic int sender_idle_pct();
      if (accepted_ops < total_ops / 3) return 21;
      if (accepted_ops < 2 * total_ops / 3) return 77;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_ops < total_ops / 3) return 77;
      if (accepted_ops < 2 * total_ops / 3) return 21;
      return 0;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   // driver: prediction is taken at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         accepted_ops <= 0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_mem[i] = 1'b0;
            tag_mem[i]   = '0;
            frame_mem[i] = '0;
            stamp_mem[i] = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            xlat_result_q.push_back(xlat_apply(req_data));
            accepted_ops <= accepted_ops + 1;
         end
         if (!req_valid || !req_stall) begin
            if (tlb_op_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               req_valid <= 1'b1;
               req_data  <= tlb_op_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (xlat_result_q.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual %h",
                        $time, rsp_data);
               err_cnt++;
            end else begin
               exp_r = xlat_result_q.pop_front();
               check_field("hit", 32'(exp_r.hit), 32'(rsp_data.hit));
               check_field("ppn_out", 32'(exp_r.ppn_out), 32'(rsp_data.ppn_out));
               check_field("slot", 32'(exp_r.slot), 32'(rsp_data.slot));
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stall_run <= 0;
      else
         stall_run <= stall_run + 1;
   end

   initial begin
      while (stall_run < WATCHDOG_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [VPN_W-1:0] vpn_pool [VPN_POOL_SZ];
      logic [PPN_W-1:0] ppn_pool [PPN_POOL_SZ];
      logic [CYC_W-1:0] cyc_now;
      logic [VPN_W-1:0] vpn;
      logic [PPN_W-1:0] ppn;
      logic [CYC_W-1:0] cyc;
      int               r;

      // directed: empty buffer, extremes, duplicates, page fault, full-buffer eviction
      push_op(OP_LOOKUP, 32'h0, 20'h0, 32'h0);
      push_op(OP_RSVD, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
      push_op(OP_FILL, 32'h0, 20'h0, 32'h0);
      push_op(OP_FILL, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
      push_op(OP_LOOKUP, 32'hFFFF_FFFF, 20'h0, 32'h1);
      push_op(OP_LOOKUP, 32'h0, 20'hF_FFFF, 32'h5);
      push_op(OP_FILL, 32'h1234, 20'h7, 32'd10);
      push_op(OP_FILL, 32'h1234, 20'h8, 32'd11);
      // duplicate tag: lowest slot reported, both stamps touched
      push_op(OP_LOOKUP, 32'h1234, 20'h0, 32'd20);
      // page fault drops the slot holding frame FFFFF, refill lands there
      push_op(OP_PF_FILL, 32'hABCD, 20'hF_FFFF, 32'd30);
      for (int i = 0; i < 12; i++)
         push_op(OP_FILL, VPN_W'(32'h100 + i), PPN_W'(32'h100 + i), 32'd40);
      push_op(OP_FILL, 32'h5555, 20'h3, 32'd50);
      // tied oldest stamps: lowest index wins
      push_op(OP_FILL, 32'h6666, 20'h4, 32'd60);
      push_op(OP_LOOKUP, 32'hDEAD, 20'h0, 32'd70);
      // two page faults on the same frame: the second drops the entry the first just filled
      push_op(OP_PF_FILL, 32'h7777, 20'h8, 32'h8000_0000);
      push_op(OP_PF_FILL, 32'h8888, 20'h8, 32'h8000_0001);

      for (int i = 0; i < VPN_POOL_SZ; i++) vpn_pool[i] = $urandom;
      for (int i = 0; i < PPN_POOL_SZ; i++) ppn_pool[i] = PPN_W'($urandom);
      cyc_now = $urandom_range(1000);

      // random: small tag and frame pools keep hits, evictions and page faults frequent
      for (int n = 0; n < RAND_ITEMS; n++) begin
         r       = $urandom_range(99);
         cyc_now = cyc_now + $urandom_range(1, 8);
         vpn = ($urandom_range(9) == 0) ? $urandom : vpn_pool[$urandom_range(VPN_POOL_SZ - 1)];
         ppn = ($urandom_range(9) == 0) ? PPN_W'($urandom)
                                        : ppn_pool[$urandom_range(PPN_POOL_SZ - 1)];
         cyc = ($urandom_range(99) < 15) ? $urandom : cyc_now;
         if (r < 50)
            push_op(OP_LOOKUP, vpn, PPN_W'($urandom), cyc);
         else if (r < 75)
            push_op(OP_FILL, vpn, ppn, cyc);
         else if (r < 95)
            push_op(OP_PF_FILL, vpn, ppn, cyc);
         else
            push_op(OP_RSVD, $urandom, PPN_W'($urandom), $urandom);
      end
      total_ops = tlb_op_q.size();

      wait (!reset);
      while (tlb_op_q.size() != 0 || req_valid || xlat_result_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/tlbfa_pkg.sv
rtl/core/tlbfa_store.sv
rtl/core/tlbfa_scan.sv
rtl/core/tlb_fully_assoc_lru_unit.sv
sim/tb_tlb_fully_assoc_lru_unit.sv
